// ===== sv/cba_pkg.sv =====
package cba_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int ID_BITS         = 8;
  localparam int START_W         = 8;
  localparam int COUNT_W         = 9;
  localparam int SIZE_W          = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam int STEP_W = 3;
  localparam int COND_W = 3;

  localparam logic [STEP_W-1:0] ST_CLEAR  = 3'd0;
  localparam logic [STEP_W-1:0] ST_IDLE   = 3'd1;
  localparam logic [STEP_W-1:0] ST_BOUND  = 3'd2;
  localparam logic [STEP_W-1:0] ST_SCAN   = 3'd3;
  localparam logic [STEP_W-1:0] ST_DRAIN  = 3'd4;
  localparam logic [STEP_W-1:0] ST_DECIDE = 3'd5;
  localparam logic [STEP_W-1:0] ST_MARK   = 3'd6;
  localparam logic [STEP_W-1:0] ST_EMIT   = 3'd7;

  localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
  localparam logic [COND_W-1:0] C_ADDR_LAST = 3'd1;
  localparam logic [COND_W-1:0] C_BEAT      = 3'd2;
  localparam logic [COND_W-1:0] C_OOR       = 3'd3;
  localparam logic [COND_W-1:0] C_AT_END    = 3'd4;
  localparam logic [COND_W-1:0] C_FAIL      = 3'd5;
  localparam logic [COND_W-1:0] C_OUT_FREE  = 3'd6;
  localparam logic [COND_W-1:0] C_NEVER     = 3'd7;

  typedef struct packed {
    logic [START_W-1:0] start_block;
    logic [COUNT_W-1:0] block_count;
  } in_beat_t;

  typedef struct packed {
    logic               granted;
    logic [ID_BITS-1:0] file_number;
  } out_beat_t;

  typedef struct packed {
    logic              clr;
    logic              take;
    logic              rd;
    logic              wr;
    logic              load_addr;
    logic              fail_cond;
    logic              emit;
    logic              nxt_inc;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    logic addr_last;
    logic beat;
    logic oor;
    logic at_end;
    logic fail;
    logic out_free;
  } sts_t;

  // microcode ROM
  function automatic ctl_t cba_rom(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '0;
    unique case (step)
      ST_CLEAR: begin
        w.clr = 1'b1; w.cond = C_ADDR_LAST; w.tgt = ST_IDLE;
      end
      ST_IDLE: begin
        w.take = 1'b1; w.cond = C_BEAT; w.tgt = ST_BOUND;
      end
      ST_BOUND: begin
        w.fail_cond = 1'b1; w.nxt_inc = 1'b1; w.cond = C_OOR; w.tgt = ST_EMIT;
      end
      ST_SCAN: begin
        w.rd = 1'b1; w.cond = C_AT_END; w.tgt = ST_DRAIN;
      end
      ST_DRAIN: begin
        w.load_addr = 1'b1; w.cond = C_ALWAYS; w.tgt = ST_DECIDE;
      end
      ST_DECIDE: begin
        w.nxt_inc = 1'b1; w.cond = C_FAIL; w.tgt = ST_EMIT;
      end
      ST_MARK: begin
        w.wr = 1'b1; w.cond = C_AT_END; w.tgt = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit = 1'b1; w.cond = C_OUT_FREE; w.tgt = ST_IDLE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/cba_seq.sv =====
module cba_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  cba_pkg::sts_t sts,
  output cba_pkg::ctl_t ctl
);
  import cba_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              cond_true;

  assign ctl = cba_rom(step_r);

  always_comb begin
    unique case (ctl.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_ADDR_LAST: cond_true = sts.addr_last;
      C_BEAT:      cond_true = sts.beat;
      C_OOR:       cond_true = sts.oor;
      C_AT_END:    cond_true = sts.at_end;
      C_FAIL:      cond_true = sts.fail;
      C_OUT_FREE:  cond_true = sts.out_free;
      C_NEVER:     cond_true = 1'b0;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cond_true) begin
      step_nxt = ctl.tgt;
    end else if (ctl.nxt_inc) begin
      step_nxt = step_r + 1'b1;
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== sv/cba_dp.sv =====
module cba_dp #(
  parameter int STORE_DEPTH = cba_pkg::STORE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cba_pkg::ctl_t                   ctl,
  output cba_pkg::sts_t                   sts,
  input  logic                            in_valid,
  input  cba_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cba_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [cba_pkg::SIZE_W-1:0]      cfg_wdata
);
  import cba_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;

  logic               used_mem [STORE_DEPTH];
  logic [ID_BITS-1:0] owner_mem [STORE_DEPTH];

  logic [CW-1:0]      addr_r;
  logic [CW-1:0]      end_r;
  logic [START_W-1:0] start_r;
  logic [ID_BITS-1:0] cnt_r;
  logic [ID_BITS-1:0] id_r;
  logic [SIZE_W-1:0]  size_r;
  logic               ok_r;
  logic               rd_vld_r;
  logic               used_rd_r;
  logic               out_valid_r;
  out_beat_t          out_data_r;

  logic [CW-1:0]      lim;
  logic               beat;
  logic               at_end;
  logic               out_free;
  logic               mem_we;
  logic               own_we;
  logic [AW-1:0]      idx;

  assign beat     = in_valid & ctl.take;
  assign at_end   = (addr_r == end_r);
  assign out_free = !out_valid_r || !out_stall;
  assign idx      = addr_r[AW-1:0];
  assign mem_we   = ctl.clr | (ctl.wr & !at_end);
  assign own_we   = ctl.wr & !at_end;
  assign lim      = (CW'(size_r) > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : CW'(size_r);

  assign sts.addr_last = (addr_r == CW'(STORE_DEPTH - 1));
  assign sts.beat      = beat;
  assign sts.oor       = (end_r > lim);
  assign sts.at_end    = at_end;
  assign sts.fail      = !ok_r;
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[idx] <= !ctl.clr;
    end
    used_rd_r <= used_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[idx] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      cnt_r       <= '0;
      size_r      <= SIZE_RESET;
      ok_r        <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      rd_vld_r <= ctl.rd & !at_end;
      priority if (beat) begin
        addr_r <= CW'(in_data.start_block);
      end else if (ctl.load_addr) begin
        addr_r <= CW'(start_r);
      end else if (ctl.clr || ((ctl.rd || ctl.wr) && !at_end)) begin
        addr_r <= addr_r + 1'b1;
      end
      if (beat) begin
        cnt_r <= cnt_r + 1'b1;
      end
      priority if (beat) begin
        ok_r <= 1'b1;
      end else if (ctl.fail_cond && sts.oor) begin
        ok_r <= 1'b0;
      end else if (rd_vld_r && used_rd_r) begin
        ok_r <= 1'b0;
      end
      if (ctl.emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      start_r <= in_data.start_block;
      end_r   <= CW'(in_data.start_block) + CW'(in_data.block_count);
      id_r    <= cnt_r;
    end
    if (ctl.emit && out_free) begin
      out_data_r.granted     <= ok_r;
      out_data_r.file_number <= id_r;
    end
  end

endmodule

// ===== sv/contiguous_block_allocator_top.sv =====
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall  | in_data   (start_block, block_count)
// out     | out | out_valid/out_stall| out_data  (granted, file_number)
// cfg     | in  | cfg_we            | cfg_wdata (store_size)
//
// One request at a time through the one-port bitmap RAM, one block per cycle:
// a grant is loaded after a bound check, a scan of its blocks, then a mark pass;
// a refusal right after the bound check if out of range, or after a failed scan.
// After reset a clearing pass over every block runs; in_stall stays high.
// The result sits in an output register; the next beat can be taken the cycle after.
// A stalled output holds the sequencer in its emit step until it frees up.
module contiguous_block_allocator_top #(
  parameter int STORE_DEPTH = cba_pkg::STORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cba_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cba_pkg::out_beat_t         out_data,
  input  logic                       cfg_we,
  input  logic [cba_pkg::SIZE_W-1:0] cfg_wdata
);
  import cba_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign in_stall = !ctl.take;

  cba_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  cba_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== sv/cba_chk.sv =====
module cba_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cba_pkg::out_beat_t out_data
);
  import cba_pkg::*;

  logic               in_acc;
  logic               out_acc;
  logic [1:0]         pend_r;
  logic               seen_r;
  logic [ID_BITS-1:0] last_fn_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= 1'b0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_fn_r <= out_data.file_number;
    end
  end

  // result beats never outrun request beats
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result beat without a request");

  // file numbers advance by one per beat
  a_fn_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && seen_r) |-> (out_data.file_number == last_fn_r + 1'b1))
    else $error("file number skipped");

  // one request in flight: stall right after a take
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("second beat taken while busy");

  // clearing pass holds off requests after reset
  a_rst_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind contiguous_block_allocator_top cba_chk u_cba_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
